// ===== rtl/nnsag_pkg.sv =====
// shared types and constants for the nearest-neighbour scaler address generator
`default_nettype none

package nnsag_pkg;

   localparam int MAX_DIM_DEFAULT     = 16384;
   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int PIXEL_SHIFT_DEFAULT = 3;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [14:0] SRC_WIDTH_RESET     = 15'd1;
   localparam logic [14:0] SRC_HEIGHT_RESET    = 15'd1;
   localparam logic [14:0] DST_WIDTH_RESET     = 15'd1;
   localparam logic [14:0] DST_HEIGHT_RESET    = 15'd1;
   localparam logic [31:0] X_STEP_RESET        = 32'd65536;
   localparam logic [31:0] Y_STEP_RESET        = 32'd65536;
   localparam logic [23:0] SRC_ROW_BYTES_RESET = 24'd8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH     = 3'd0,
      CSR_SRC_HEIGHT    = 3'd1,
      CSR_DST_WIDTH     = 3'd2,
      CSR_DST_HEIGHT    = 3'd3,
      CSR_X_STEP        = 3'd4,
      CSR_Y_STEP        = 3'd5,
      CSR_SRC_ROW_BYTES = 3'd6
   } csr_index_type;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] x_start;
      logic [15:0] y_start;
   } req_type;

   typedef struct packed {
      logic [39:0] src_offset;
      logic [13:0] dst_x;
      logic [13:0] dst_y;
      logic        row_end;
      logic        frame_end;
   } rsp_type;

   typedef struct packed {
      logic [14:0] src_width;
      logic [14:0] src_height;
      logic [14:0] dst_width;
      logic [14:0] dst_height;
      logic [31:0] x_step;
      logic [31:0] y_step;
      logic [23:0] src_row_bytes;
   } cfg_type;

   // one pixel between the walker and the output register
   typedef struct packed {
      logic [14:0] x_index;
      logic [14:0] row_index;
      logic [23:0] row_bytes;
      logic [13:0] dst_x;
      logic [13:0] dst_y;
      logic        row_end;
      logic        frame_end;
   } stage_type;

endpackage

`default_nettype wire

// ===== rtl/nnsag_csr.sv =====
// configuration registers of the scaler address generator
`default_nettype none

module nnsag_csr (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_wr_en,
   input  wire  [nnsag_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [nnsag_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   output nnsag_pkg::cfg_type                   cfg
);

   nnsag_pkg::cfg_type cfg_ff;
   nnsag_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            nnsag_pkg::CSR_SRC_WIDTH:     cfg_in.src_width     = csr_wr_data[14:0];
            nnsag_pkg::CSR_SRC_HEIGHT:    cfg_in.src_height    = csr_wr_data[14:0];
            nnsag_pkg::CSR_DST_WIDTH:     cfg_in.dst_width     = csr_wr_data[14:0];
            nnsag_pkg::CSR_DST_HEIGHT:    cfg_in.dst_height    = csr_wr_data[14:0];
            nnsag_pkg::CSR_X_STEP:        cfg_in.x_step        = csr_wr_data[31:0];
            nnsag_pkg::CSR_Y_STEP:        cfg_in.y_step        = csr_wr_data[31:0];
            nnsag_pkg::CSR_SRC_ROW_BYTES: cfg_in.src_row_bytes = csr_wr_data[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width     <= nnsag_pkg::SRC_WIDTH_RESET;
         cfg_ff.src_height    <= nnsag_pkg::SRC_HEIGHT_RESET;
         cfg_ff.dst_width     <= nnsag_pkg::DST_WIDTH_RESET;
         cfg_ff.dst_height    <= nnsag_pkg::DST_HEIGHT_RESET;
         cfg_ff.x_step        <= nnsag_pkg::X_STEP_RESET;
         cfg_ff.y_step        <= nnsag_pkg::Y_STEP_RESET;
         cfg_ff.src_row_bytes <= nnsag_pkg::SRC_ROW_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/nnsag_walk.sv =====
// raster walker: frame state, fixed-point accumulators and the stage register
`default_nettype none

module nnsag_walk #(
   parameter int MAX_DIM   = nnsag_pkg::MAX_DIM_DEFAULT,
   parameter int FRAC_BITS = nnsag_pkg::FRAC_BITS_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  nnsag_pkg::req_type     req_data,
   input  nnsag_pkg::cfg_type     cfg,
   input  wire                    out_ready,
   output logic                   stg_valid,
   output nnsag_pkg::stage_type   stg_data
);

   localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int SCL_W = 16 + FRAC_BITS;

   function automatic logic [31:0] scale_offset(input logic [15:0] v);
      logic [SCL_W-1:0] t;
      t = {v, FRAC_BITS'(0)};
      return 32'(t >> 16);
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [14:0] src_index(input logic [31:0] accum,
                                             input logic [14:0] bound);
      logic [14:0] lim;
      logic [31:0] idx;
      lim = (bound == 15'd0) ? 15'd1 : bound;
      idx = accum >> FRAC_BITS;
      return (idx >= 32'(lim)) ? (lim - 15'd1) : 15'(idx);
   endfunction

   function automatic logic [DIM_W-1:0] dst_dim(input logic [14:0] r);
      logic [DIM_W-1:0] d;
      if (r == 15'd0) begin
         d = DIM_W'(1);
      end else if (32'(r) > 32'(MAX_DIM)) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(r);
      end
      return d;
   endfunction

   logic              active_ff,    active_in;
   logic [CNT_W-1:0]  col_count_ff, col_count_in;
   logic [CNT_W-1:0]  row_count_ff, row_count_in;
   logic [31:0]       x_accum_ff,   x_accum_in;
   logic [31:0]       y_accum_ff,   y_accum_in;
   logic [15:0]       x_origin_ff,  x_origin_in;
   logic [14:0]       row_index_ff, row_index_in;
   logic [23:0]       row_bytes_ff, row_bytes_in;
   logic              stg_valid_ff, stg_valid_in;
   nnsag_pkg::stage_type stg_ff,    stg_in;

   logic             accept;
   logic [DIM_W-1:0] dw;
   logic [DIM_W-1:0] dh;
   logic             row_end;
   logic             frame_end;
   logic [31:0]      y_next;
   logic [31:0]      y_start_scaled;

   assign req_ready = !stg_valid_ff || out_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      dw             = dst_dim(cfg.dst_width);
      dh             = dst_dim(cfg.dst_height);
      row_end        = DIM_W'(col_count_ff) >= (dw - DIM_W'(1));
      frame_end      = row_end && (DIM_W'(row_count_ff) >= (dh - DIM_W'(1)));
      y_next         = sat_add(y_accum_ff, cfg.y_step);
      y_start_scaled = scale_offset(req_data.y_start);

      active_in    = active_ff;
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      x_accum_in   = x_accum_ff;
      y_accum_in   = y_accum_ff;
      x_origin_in  = x_origin_ff;
      row_index_in = row_index_ff;
      row_bytes_in = row_bytes_ff;
      stg_valid_in = stg_valid_ff;

      stg_in.x_index   = src_index(x_accum_ff, cfg.src_width);
      stg_in.row_index = row_index_ff;
      stg_in.row_bytes = row_bytes_ff;
      stg_in.dst_x     = 14'(col_count_ff);
      stg_in.dst_y     = 14'(row_count_ff);
      stg_in.row_end   = row_end;
      stg_in.frame_end = frame_end;

      if (req_ready) begin
         stg_valid_in = 1'b0;
      end

      if (accept) begin
         if (req_data.op == nnsag_pkg::OP_START) begin
            x_origin_in  = req_data.x_start;
            x_accum_in   = scale_offset(req_data.x_start);
            y_accum_in   = y_start_scaled;
            col_count_in = '0;
            row_count_in = '0;
            active_in    = 1'b1;
            row_index_in = src_index(y_start_scaled, cfg.src_height);
            row_bytes_in = cfg.src_row_bytes;
         end else if (active_ff) begin
            stg_valid_in = 1'b1;
            if (frame_end) begin
               active_in = 1'b0;
            end else if (row_end) begin
               row_count_in = row_count_ff + CNT_W'(1);
               col_count_in = '0;
               y_accum_in   = y_next;
               x_accum_in   = scale_offset(x_origin_ff);
               row_index_in = src_index(y_next, cfg.src_height);
               row_bytes_in = cfg.src_row_bytes;
            end else begin
               col_count_in = col_count_ff + CNT_W'(1);
               x_accum_in   = sat_add(x_accum_ff, cfg.x_step);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         col_count_ff <= '0;
         row_count_ff <= '0;
         x_accum_ff   <= '0;
         y_accum_ff   <= '0;
         x_origin_ff  <= '0;
         row_index_ff <= '0;
         row_bytes_ff <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         x_accum_ff   <= x_accum_in;
         y_accum_ff   <= y_accum_in;
         x_origin_ff  <= x_origin_in;
         row_index_ff <= row_index_in;
         row_bytes_ff <= row_bytes_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         stg_ff <= stg_in;
      end
   end

   assign stg_valid = stg_valid_ff;
   assign stg_data  = stg_ff;

endmodule

`default_nettype wire

// ===== rtl/nnsag_out.sv =====
// source offset arithmetic and the result register
`default_nettype none

module nnsag_out #(
   parameter int PIXEL_SHIFT = nnsag_pkg::PIXEL_SHIFT_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    stg_valid,
   input  nnsag_pkg::stage_type   stg_data,
   output logic                   out_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output nnsag_pkg::rsp_type     rsp_data
);

   logic               rsp_valid_ff, rsp_valid_in;
   nnsag_pkg::rsp_type rsp_ff,       rsp_in;
   logic [38:0]        row_base;

   assign out_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      row_base          = stg_data.row_index * stg_data.row_bytes;
      rsp_in.src_offset = 40'(row_base) + (40'(stg_data.x_index) << PIXEL_SHIFT);
      rsp_in.dst_x      = stg_data.dst_x;
      rsp_in.dst_y      = stg_data.dst_y;
      rsp_in.row_end    = stg_data.row_end;
      rsp_in.frame_end  = stg_data.frame_end;
      rsp_valid_in      = out_ready ? stg_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/nearest_neighbour_scale_addr_gen_unit.sv =====
// top level of the nearest-neighbour scaler source address generator
// usage:
//   software writes the source and destination sizes, the 16.16 steps and the
//   source row pitch through the csr write port, then sends a start request
//   (op start) carrying the fractional x and y offsets. each advance request
//   after that yields one response for the next destination pixel in raster
//   order; a start yields none, and advances outside a frame yield none.
// path: the edge that accepts a request fills the walker stage register; the
//   result register is filled from it through the offset multiply when the
//   result register is empty or its response is taken.
// throughput: one request per cycle, one response per cycle while rsp_ready
//   stays high; the accumulators and counters update in the cycle of acceptance,
//   so requests may follow back to back.
// stall: when rsp_ready is low the result register holds; one more pixel can
//   sit in the stage register, after which req_ready drops until a response
//   is taken.
// reset: no frame is open, the csr registers return to unit sizes and unit
//   steps, both channels are empty. there is no clearing pass.
`default_nettype none

module nearest_neighbour_scale_addr_gen_unit #(
   parameter int MAX_DIM     = nnsag_pkg::MAX_DIM_DEFAULT,
   parameter int FRAC_BITS   = nnsag_pkg::FRAC_BITS_DEFAULT,
   parameter int PIXEL_SHIFT = nnsag_pkg::PIXEL_SHIFT_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  nnsag_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output nnsag_pkg::rsp_type                   rsp_data,
   input  wire                                  csr_wr_en,
   input  wire  [nnsag_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [nnsag_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   nnsag_pkg::cfg_type   cfg;
   nnsag_pkg::stage_type stg_data;
   logic                 stg_valid;
   logic                 out_ready;

   nnsag_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   nnsag_walk #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .out_ready (out_ready),
      .stg_valid (stg_valid),
      .stg_data  (stg_data)
   );

   nnsag_out #(
      .PIXEL_SHIFT (PIXEL_SHIFT)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .stg_valid (stg_valid),
      .stg_data  (stg_data),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the nearest-neighbour scaler source address generator
`default_nettype none

module testbench;

   localparam int          WATCHDOG_LIMIT   = 1000;
   localparam bit [2:0]    CSR_UNUSED_INDEX = 3'd7;
   localparam int          RANDOM_PHASES    = 11;
   localparam int          PHASE_REQUESTS   = 100;

   class pixel_scoreboard;
      bit [14:0]   src_width, src_height, dst_width, dst_height;
      bit [31:0]   x_step, y_step;
      bit [23:0]   src_row_bytes;
      bit          in_frame;
      int unsigned col_count, row_count;
      bit [31:0]   x_accum, y_accum;
      bit [15:0]   x_origin;
      bit [39:0]   row_base;
      nnsag_pkg::rsp_type expected_pixels[$];
      int unsigned errors, pixels_checked, frames_closed, requests_seen;

      function new();
         src_width     = nnsag_pkg::SRC_WIDTH_RESET;
         src_height    = nnsag_pkg::SRC_HEIGHT_RESET;
         dst_width     = nnsag_pkg::DST_WIDTH_RESET;
         dst_height    = nnsag_pkg::DST_HEIGHT_RESET;
         x_step        = nnsag_pkg::X_STEP_RESET;
         y_step        = nnsag_pkg::Y_STEP_RESET;
         src_row_bytes = nnsag_pkg::SRC_ROW_BYTES_RESET;
      endfunction

      function int unsigned dest_dim(bit [14:0] value);
         if (value == 0) return 1;
         if (value > nnsag_pkg::MAX_DIM_DEFAULT) return nnsag_pkg::MAX_DIM_DEFAULT;
         return 32'(value);
      endfunction

      function bit [31:0] source_index(bit [31:0] accum, bit [14:0] bound);
         bit [31:0] lim, idx;
         lim = (bound == 0) ? 32'd1 : 32'(bound);
         idx = accum >> nnsag_pkg::FRAC_BITS_DEFAULT;
         return (idx >= lim) ? lim - 1 : idx;
      endfunction

      function bit [31:0] add_saturated(bit [31:0] a, bit [31:0] b);
         bit [32:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      endfunction

      function bit [31:0] origin_accum(bit [15:0] offset);
         return 32'((64'(offset) << nnsag_pkg::FRAC_BITS_DEFAULT) >> 16);
      endfunction

      function void begin_row();
         bit [63:0] product;
         product  = 64'(source_index(y_accum, src_height)) * 64'(src_row_bytes);
         row_base = product[39:0];
      endfunction

      function void set_register(bit [2:0] index, bit [31:0] value);
         case (index)
            nnsag_pkg::CSR_SRC_WIDTH:     src_width     = value[14:0];
            nnsag_pkg::CSR_SRC_HEIGHT:    src_height    = value[14:0];
            nnsag_pkg::CSR_DST_WIDTH:     dst_width     = value[14:0];
            nnsag_pkg::CSR_DST_HEIGHT:    dst_height    = value[14:0];
            nnsag_pkg::CSR_X_STEP:        x_step        = value;
            nnsag_pkg::CSR_Y_STEP:        y_step        = value;
            nnsag_pkg::CSR_SRC_ROW_BYTES: src_row_bytes = value[23:0];
            default: ;
         endcase
      endfunction

      function void note_request(nnsag_pkg::req_type r);
         int unsigned        dw, dh;
         bit [31:0]          xi;
         nnsag_pkg::rsp_type px;
         requests_seen++;
         if (r.op == nnsag_pkg::OP_START) begin
            x_origin  = r.x_start;
            x_accum   = origin_accum(r.x_start);
            y_accum   = origin_accum(r.y_start);
            col_count = 0;
            row_count = 0;
            in_frame  = 1'b1;
            begin_row();
            return;
         end
         if (!in_frame) return;
         dw = dest_dim(dst_width);
         dh = dest_dim(dst_height);
         xi = source_index(x_accum, src_width);
         px.src_offset = row_base + (40'(xi) << nnsag_pkg::PIXEL_SHIFT_DEFAULT);
         px.dst_x      = col_count[13:0];
         px.dst_y      = row_count[13:0];
         px.row_end    = col_count >= dw - 1;
         px.frame_end  = px.row_end && (row_count >= dh - 1);
         expected_pixels.push_back(px);
         if (px.frame_end) begin
            in_frame = 1'b0;
            frames_closed++;
         end else if (px.row_end) begin
            row_count++;
            col_count = 0;
            y_accum   = add_saturated(y_accum, y_step);
            x_accum   = origin_accum(x_origin);
            begin_row();
         end else begin
            col_count++;
            x_accum = add_saturated(x_accum, x_step);
         end
      endfunction

      function void check_response(nnsag_pkg::rsp_type got);
         nnsag_pkg::rsp_type want;
         if (expected_pixels.size() == 0) begin
            $error("response with no pixel pending: %h", got);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (got.src_offset !== want.src_offset) begin
            $error("src_offset expected %h actual %h", want.src_offset, got.src_offset);
            errors++;
         end
         if (got.dst_x !== want.dst_x) begin
            $error("dst_x expected %0d actual %0d", want.dst_x, got.dst_x);
            errors++;
         end
         if (got.dst_y !== want.dst_y) begin
            $error("dst_y expected %0d actual %0d", want.dst_y, got.dst_y);
            errors++;
         end
         if (got.row_end !== want.row_end) begin
            $error("row_end expected %b actual %b", want.row_end, got.row_end);
            errors++;
         end
         if (got.frame_end !== want.frame_end) begin
            $error("frame_end expected %b actual %b", want.frame_end, got.frame_end);
            errors++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   nnsag_pkg::req_type                req_data;
   logic                              rsp_valid;
   logic                              rsp_ready;
   nnsag_pkg::rsp_type                rsp_data;
   logic                              csr_wr_en;
   logic [nnsag_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [nnsag_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   pixel_scoreboard sb = new();
   int              idle_odds;
   int              settings_count;
   int              idle_cycles;

   nearest_neighbour_scale_addr_gen_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.set_register(csr_index, csr_wr_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (req_valid && req_ready) sb.note_request(req_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("testbench failed");
         $finish;
      end
   end

   // receiver stalls in short bursts
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(nnsag_pkg::req_type r);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_start(bit [15:0] x_off, bit [15:0] y_off);
      nnsag_pkg::req_type r;
      r.op      = nnsag_pkg::OP_START;
      r.x_start = x_off;
      r.y_start = y_off;
      send_request(r);
   endtask

   task automatic send_advance();
      nnsag_pkg::req_type r;
      r.op      = nnsag_pkg::OP_ADVANCE;
      r.x_start = 16'($urandom);
      r.y_start = 16'($urandom);
      send_request(r);
   endtask

   // wait until every pixel has come out, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(bit [2:0] index, bit [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(negedge clock);
   endtask

   task automatic configure(bit [14:0] sw, bit [14:0] sh, bit [14:0] dw, bit [14:0] dh,
                            bit [31:0] xs, bit [31:0] ys, bit [23:0] rb);
      csr_write(nnsag_pkg::CSR_SRC_WIDTH,     {17'($urandom), sw});
      csr_write(nnsag_pkg::CSR_SRC_HEIGHT,    {17'($urandom), sh});
      csr_write(nnsag_pkg::CSR_DST_WIDTH,     {17'($urandom), dw});
      csr_write(nnsag_pkg::CSR_DST_HEIGHT,    {17'($urandom), dh});
      csr_write(nnsag_pkg::CSR_X_STEP,        xs);
      csr_write(nnsag_pkg::CSR_Y_STEP,        ys);
      csr_write(nnsag_pkg::CSR_SRC_ROW_BYTES, {8'($urandom), rb});
      csr_write(CSR_UNUSED_INDEX,  $urandom);
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   task automatic program_random_settings();
      bit [14:0] dims[4];
      bit [31:0] steps[2];
      bit [23:0] rb;
      for (int i = 0; i < 2; i++) begin
         case ($urandom_range(0, 9))
            0:       dims[i] = 15'd0;
            1:       dims[i] = 15'd16384;
            2:       dims[i] = 15'd32767;
            3:       dims[i] = 15'd1;
            default: dims[i] = 15'($urandom_range(2, 40));
         endcase
      end
      for (int i = 2; i < 4; i++) begin
         case ($urandom_range(0, 9))
            0:       dims[i] = 15'd0;
            1:       dims[i] = 15'd1;
            default: dims[i] = 15'($urandom_range(2, 9));
         endcase
      end
      for (int i = 0; i < 2; i++) begin
         case ($urandom_range(0, 7))
            0:       steps[i] = 32'd0;
            1:       steps[i] = 32'hFFFF_FFFF;
            2:       steps[i] = $urandom;
            default: steps[i] = ((dims[i] == 0 ? 32'd1 : 32'(dims[i])) << 16)
                                / (dims[i + 2] == 0 ? 32'd1 : 32'(dims[i + 2]))
                                + $urandom_range(0, 255);
         endcase
      end
      case ($urandom_range(0, 5))
         0:       rb = 24'd8;
         1:       rb = 24'hFF_FFFF;
         2:       rb = 24'($urandom);
         default: rb = 24'($urandom_range(8, 4096));
      endcase
      configure(dims[0], dims[1], dims[2], dims[3], steps[0], steps[1], rb);
   endtask

   // mostly whole frames, some cut short by a new start, some stray advances
   task automatic run_frames(int budget);
      int          sent;
      int unsigned frame_len, n;
      bit [15:0]   x_off, y_off;
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(0, 5))
            0:       begin x_off = 16'd0;          y_off = 16'hFFFF;       end
            1:       begin x_off = 16'hFFFF;       y_off = 16'd0;          end
            default: begin x_off = 16'($urandom);  y_off = 16'($urandom);  end
         endcase
         send_start(x_off, y_off);
         sent++;
         frame_len = sb.dest_dim(sb.dst_width) * sb.dest_dim(sb.dst_height);
         n = frame_len;
         if (n > 60 || $urandom_range(0, 5) == 0) n = $urandom_range(0, (n > 60) ? 60 : n);
         repeat (n) send_advance();
         sent += n;
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) send_advance();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wr_data = '0;
      idle_odds   = 4;
      settings_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // unit sizes after reset: one-pixel frame, then an advance with no frame
      send_start(16'd0, 16'd0);
      send_advance();
      send_advance();

      settle();
      configure(15'd4, 15'd3, 15'd3, 15'd2, 32'h0001_8000, 32'h0001_8000, 24'd32);
      send_start(16'hFFFF, 16'hFFFF);
      repeat (7) send_advance();
      // a fresh frame, then a start inside it after two pixels drops it
      send_start(16'h8000, 16'h0000);
      repeat (2) send_advance();
      send_start(16'h1234, 16'hFEDC);
      repeat (3) send_advance();

      // zero sizes read as one
      settle();
      configure(15'd0, 15'd0, 15'd0, 15'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
      send_start(16'hFFFF, 16'hFFFF);
      send_advance();

      // saturating accumulators clamp to the far edge
      settle();
      configure(15'd32767, 15'd32767, 15'd3, 15'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                24'hFF_FFFF);
      send_start(16'hFFFF, 16'hFFFF);
      repeat (4) send_advance();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         idle_odds = (phase >= RANDOM_PHASES - 2) ? 0 : (phase % 3 == 0) ? 0 : 3 + phase % 4;
         case (phase)
            0:       configure(15'd1, 15'd1, 15'd4, 15'd3, 32'd0, 32'd0, 24'd8);
            1:       configure(15'd16384, 15'd16384, 15'd32767, 15'd16384,
                               32'hFFFF_FFFF, 32'h0001_0000, 24'hFF_FFFF);
            default: program_random_settings();
         endcase
         if (phase == 5) begin
            run_frames(PHASE_REQUESTS / 2);
            settle();
            run_frames(PHASE_REQUESTS / 2);
         end else begin
            run_frames(PHASE_REQUESTS);
         end
      end

      settle();
      repeat (10) @(negedge clock);
      if (sb.expected_pixels.size() != 0)
         $error("%0d pixels never came out", sb.expected_pixels.size());
      $display("run: %0d requests, %0d pixels compared, %0d frames run to the end",
               sb.requests_seen, sb.pixels_checked, sb.frames_closed);
      $display("run: %0d register settings incl. zero, clamped and saturating values",
               settings_count);
      if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/nnsag_pkg.sv
rtl/nnsag_csr.sv
rtl/nnsag_walk.sv
rtl/nnsag_out.sv
rtl/nearest_neighbour_scale_addr_gen_unit.sv
sim/testbench.sv
